// ===== sv/gss_pkg.sv =====
package gss_pkg;

    // Geometry and fixed-point format
    localparam int NUM_COLS    = 8;
    localparam int COL_W       = $clog2(NUM_COLS);
    localparam int LEVEL_SHIFT = 29;
    localparam int LEVEL_W     = 32;
    localparam int BASE_W      = 24;
    localparam int STEP_W      = BASE_W + 14;
    localparam int ROW_W       = 3;
    localparam int MASK_W      = 8;
    localparam int IDX_W       = 6;
    localparam int VEL_W       = 7;
    localparam int RATE_W      = 3;

    // 7 << 29, one bit wider than a level so the row math cannot wrap
    localparam logic [LEVEL_W:0] FULL_SCALE = 33'h0_E000_0000;
    localparam logic [LEVEL_W:0] HALF_ROW   = 33'h0_1000_0000;

    // Reset values
    localparam logic [BASE_W-1:0] BASE_STEP_RESET = 24'd5326;
    localparam logic              FULL_BAR_RESET  = 1'b1;
    localparam logic [RATE_W-1:0] RATE_RESET      = 3'd2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Input operation codes
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SCENE  = 2'd1,
        OP_PAD    = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    // Configuration register indexes
    localparam logic CFG_BASE_STEP = 1'b0;
    localparam logic CFG_FULL_BAR  = 1'b1;

    // Classified commands
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_RATE   = 2'd1,
        CMD_TARGET = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [LEVEL_W-1:0] slider_value;
        logic [ROW_W-1:0]   top_row;
        logic [MASK_W-1:0]  lit_mask;
        logic               moved;
        logic               last;
    } t_result;

    // Step per tick: rate multiplier times base step (16000 = 16384 - 256 - 128)
    function automatic logic [STEP_W-1:0] step_of(input logic [RATE_W-1:0] rate,
                                                  input logic [BASE_W-1:0] base);
        logic [STEP_W-1:0] b;
        logic [STEP_W-1:0] s;
        b = STEP_W'(base);
        case (rate)
            3'd0:    s = (b << 14) - (b << 8) - (b << 7);
            3'd1:    s = b << 7;
            3'd2:    s = b << 5;
            3'd3:    s = b << 4;
            3'd4:    s = b << 3;
            3'd5:    s = b << 2;
            3'd6:    s = b << 1;
            default: s = b;
        endcase
        return s;
    endfunction

    // Rounded LED row of a level, 0 at the top
    function automatic logic [ROW_W-1:0] row_of(input logic [LEVEL_W-1:0] value);
        logic [LEVEL_W:0] v;
        logic [LEVEL_W:0] sum;
        logic [LEVEL_W:0] row;
        v = {1'b0, value};
        if (v >= FULL_SCALE) begin
            return '0;
        end
        sum = FULL_SCALE - v + HALF_ROW;
        row = sum >> LEVEL_SHIFT;
        if (row > 33'd7) begin
            return 3'd7;
        end
        return row[ROW_W-1:0];
    endfunction

    // Lit rows: bar from the top row down, or the top row alone
    function automatic logic [MASK_W-1:0] mask_of(input logic [ROW_W-1:0] row,
                                                  input logic full_bar);
        logic [MASK_W-1:0] m;
        m = full_bar ? (8'hFF << row) : (8'h01 << row);
        return m;
    endfunction

endpackage

// ===== sv/gss_front.sv =====
module gss_front (
    input  logic                     i_valid,
    input  logic [1:0]               i_operation,
    input  logic [gss_pkg::IDX_W-1:0] i_index,
    input  logic [gss_pkg::VEL_W-1:0] i_velocity,
    input  gss_pkg::t_q_status       i_q_status,
    output logic                     o_ready,
    output logic                     o_push,
    output gss_pkg::t_cmd            o_cmd
);
    import gss_pkg::*;

    logic keep;

    // Accept whenever the queue has room
    assign o_ready = !i_q_status.full;

    // Classify: ticks always kept, events only on a press, unused code dropped
    always_comb begin
        keep       = 1'b0;
        o_cmd.kind = CMD_TICK;
        o_cmd.idx  = i_index;
        case (t_op'(i_operation))
            OP_TICK: begin
                keep       = 1'b1;
                o_cmd.kind = CMD_TICK;
            end
            OP_SCENE: begin
                keep       = (i_velocity != '0);
                o_cmd.kind = CMD_RATE;
            end
            OP_PAD: begin
                keep       = (i_velocity != '0);
                o_cmd.kind = CMD_TARGET;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_valid && o_ready && keep;

endmodule

// ===== sv/gss_fifo.sv =====
module gss_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  gss_pkg::t_cmd       i_wdata,
    input  logic                i_pop,
    output gss_pkg::t_cmd       o_rdata,
    output gss_pkg::t_q_status  o_status
);
    import gss_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_status.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_rdata        = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/gss_back.sv =====
module gss_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration writes
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [gss_pkg::BASE_W-1:0]  i_cfg_data,
    // command queue
    input  gss_pkg::t_cmd               i_cmd,
    input  gss_pkg::t_q_status          i_q_status,
    output logic                        o_pop,
    // results
    output logic                        o_valid,
    input  logic                        i_ready,
    output gss_pkg::t_result            o_result
);
    import gss_pkg::*;

    // Slider state and configuration
    logic [LEVEL_W-1:0] r_cur [NUM_COLS];
    logic [LEVEL_W-1:0] r_tgt [NUM_COLS];
    logic [RATE_W-1:0]  r_rate;
    logic [BASE_W-1:0]  r_base;
    logic               r_full;

    // Tick sequencer
    logic               r_busy;
    logic [COL_W-1:0]   r_col;
    logic [STEP_W-1:0]  r_step;

    // Slew stage
    logic               r_p_valid;
    logic [COL_W-1:0]   r_p_col;
    logic [LEVEL_W-1:0] r_p_val;
    logic               r_p_moved;
    logic               r_p_last;

    // Output register
    logic               r_o_valid;
    t_result            r_o;

    logic               o_load;
    logic               p_adv;
    logic               col_go;
    logic [LEVEL_W-1:0] cur;
    logic [LEVEL_W-1:0] tgt;
    logic               up;
    logic [LEVEL_W-1:0] diff;
    logic [LEVEL_W-1:0] n_val;
    logic [ROW_W-1:0]   n_row;

    assign o_load = !r_o_valid || i_ready;
    assign p_adv  = !r_p_valid || o_load;
    assign col_go = r_busy && p_adv;
    assign o_pop  = !r_busy && !i_q_status.empty;

    // Slew one column toward its target, snapping when within one step
    always_comb begin
        cur  = r_cur[r_col];
        tgt  = r_tgt[r_col];
        up   = (tgt > cur);
        diff = up ? (tgt - cur) : (cur - tgt);
        if (cur == tgt) begin
            n_val = cur;
        end else if (STEP_W'(diff) <= r_step) begin
            n_val = tgt;
        end else if (up) begin
            n_val = cur + r_step[LEVEL_W-1:0];
        end else begin
            n_val = cur - r_step[LEVEL_W-1:0];
        end
    end

    assign n_row = row_of(r_p_val);

    // Control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COLS; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
            end
            r_rate    <= RATE_RESET;
            r_base    <= BASE_STEP_RESET;
            r_full    <= FULL_BAR_RESET;
            r_busy    <= 1'b0;
            r_col     <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // configuration
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_STEP: r_base <= i_cfg_data;
                    CFG_FULL_BAR:  r_full <= i_cfg_data[0];
                    default:       r_base <= r_base;
                endcase
            end

            // command dispatch
            if (o_pop) begin
                case (i_cmd.kind)
                    CMD_TICK: begin
                        r_busy <= 1'b1;
                        r_col  <= '0;
                    end
                    CMD_RATE: begin
                        r_rate <= i_cmd.idx[RATE_W-1:0];
                    end
                    CMD_TARGET: begin
                        r_tgt[i_cmd.idx[COL_W-1:0]] <=
                            {3'd7 - i_cmd.idx[IDX_W-1:COL_W], LEVEL_SHIFT'(0)};
                    end
                    default: begin
                        r_busy <= r_busy;
                    end
                endcase
            end

            // column walk
            if (col_go) begin
                r_cur[r_col] <= n_val;
                r_col        <= r_col + 1'b1;
                if (r_col == COL_W'(NUM_COLS - 1)) begin
                    r_busy <= 1'b0;
                end
            end

            if (p_adv) begin
                r_p_valid <= col_go;
            end
            if (o_load) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.kind == CMD_TICK) begin
            r_step <= step_of(r_rate, r_base);
        end
        if (col_go) begin
            r_p_col   <= r_col;
            r_p_val   <= n_val;
            r_p_moved <= (n_val != cur);
            r_p_last  <= (r_col == COL_W'(NUM_COLS - 1));
        end
        if (o_load && r_p_valid) begin
            r_o.column       <= r_p_col;
            r_o.slider_value <= r_p_val;
            r_o.top_row      <= n_row;
            r_o.lit_mask     <= mask_of(n_row, r_full);
            r_o.moved        <= r_p_moved;
            r_o.last         <= r_p_last;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_o;

endmodule

// ===== sv/grid_slew_sliders_unit.sv =====
// Eight slew-limited sliders driven by an 8x8 pad grid.
// Input stream (s_axis): one transaction per tick, scene event or pad event.
// Scene presses pick the slew rate, pad presses set a column's target level;
// releases (zero velocity) and the unused operation code are dropped.
// Output stream (m_axis): each tick yields eight transactions, columns 0 to 7
// in order, with tlast on column 7.
// Accepted transactions enter a four-entry command queue; s_axis_tready is low
// only while that queue is full.
// A tick's results pass through the command queue, dispatch, the slew stage and
// the output register, then one result per cycle while the receiver takes them.
// An event is done at its dispatch; a tick holds the back end, popping nothing,
// from dispatch until its walk of the columns through the shared slew unit ends.
// A receiver stall holds the output register and the slew stage; the column
// walk pauses and the queue fills before the input side stalls.
// Configuration writes (base step, bar mode) are to be made while the block is
// idle; the block itself does not enforce this. Reset clears levels and targets
// to zero, sets the rate select to 2, base step to 5326 and bar mode on.
module grid_slew_sliders_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // operation[1:0], index[7:2], velocity[14:8]
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // column[2:0], slider_value[34:3],
                                       // top_row[37:35], lit_mask[45:38], moved[46]
    output logic        m_axis_tlast
);
    import gss_pkg::*;

    t_cmd      push_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;
    logic      push;
    logic      pop;
    t_result   result;

    // Front: accept and classify
    gss_front u_front (
        .i_valid     (s_axis_tvalid),
        .i_operation (s_axis_tdata[1:0]),
        .i_index     (s_axis_tdata[7:2]),
        .i_velocity  (s_axis_tdata[14:8]),
        .i_q_status  (q_status),
        .o_ready     (s_axis_tready),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Command queue
    gss_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (push_cmd),
        .i_pop    (pop),
        .o_rdata  (head_cmd),
        .o_status (q_status)
    );

    // Back: slider state, slew unit and result register
    gss_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (head_cmd),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (result)
    );

    assign m_axis_tdata = {1'b0, result.moved, result.lit_mask, result.top_row,
                           result.slider_value, result.column};
    assign m_axis_tlast = result.last;

`ifndef SYNTHESIS
    // The queue is never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("command queue overflow");

    // The last transaction of a tick describes the last column
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[2:0] == 3'd7))
        else $error("tlast on wrong column");

    // Every result lights at least one LED
    a_mask_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[45:38] != 8'd0))
        else $error("empty lit mask");

    // After a column other than column 7 is taken, the next valid result is the following column
    a_col_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
            |=> (!m_axis_tvalid || (m_axis_tdata[2:0] == $past(m_axis_tdata[2:0]) + 3'd1)))
        else $error("column order broken");
`endif

endmodule

// ===== bench/tb_grid_slew_sliders_unit.sv =====
`timescale 1ns / 1ps

module tb_grid_slew_sliders_unit;
    import gss_pkg::*;

    localparam int RST_CYCLES   = 8;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 500000;

    // One input transaction as seen by the pad grid
    typedef struct {
        t_op              op;
        logic [IDX_W-1:0] index;
        logic [VEL_W-1:0] velocity;
    } t_grid_msg;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [23:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;  // operation[1:0], index[7:2], velocity[14:8]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // column[2:0], slider_value[34:3],
                                     // top_row[37:35], lit_mask[45:38], moved[46]
    logic        m_axis_tlast;

    grid_slew_sliders_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Slider model state and register copies
    logic [BASE_W-1:0]  base_step_m;
    logic               full_bar_m;
    logic [LEVEL_W-1:0] level_m [NUM_COLS];
    logic [LEVEL_W-1:0] target_m [NUM_COLS];
    logic [RATE_W-1:0]  rate_m;

    t_grid_msg pending_msgs[$];
    t_result   column_results[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_ticks = 0;
    int n_checked = 0;
    int n_settings = 0;
    int n_errors = 0;
    int cyc = 0;

    function automatic logic [63:0] rate_factor(input logic [RATE_W-1:0] r);
        case (r)
            3'd0:    return 64'd16000;
            3'd1:    return 64'd128;
            3'd2:    return 64'd32;
            3'd3:    return 64'd16;
            3'd4:    return 64'd8;
            3'd5:    return 64'd4;
            3'd6:    return 64'd2;
            default: return 64'd1;
        endcase
    endfunction

    // Short gaps mostly, a few long ones, none while in a burst stretch
    function automatic int idle_len(input bit burst);
        int k;
        if (burst) return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Slew every column one tick and queue the eight expected results
    task automatic advance_sliders();
        logic [63:0]        step;
        logic [63:0]        lvl_gap;
        logic [63:0]        row64;
        logic [63:0]        full;
        logic [LEVEL_W-1:0] prev;
        logic [LEVEL_W-1:0] nxt;
        t_result            r;
        step = rate_factor(rate_m) * 64'(base_step_m);
        full = 64'd7 << LEVEL_SHIFT;
        for (int c = 0; c < NUM_COLS; c++) begin
            prev = level_m[c];
            nxt  = prev;
            if (prev != target_m[c]) begin
                lvl_gap = (target_m[c] > prev) ? 64'(target_m[c] - prev)
                                               : 64'(prev - target_m[c]);
                if (lvl_gap <= step)
                    nxt = target_m[c];
                else if (target_m[c] > prev)
                    nxt = prev + step[LEVEL_W-1:0];
                else
                    nxt = prev - step[LEVEL_W-1:0];
            end
            level_m[c] = nxt;
            // round to nearest row, half up, clamp at the top
            if (64'(nxt) >= full) begin
                row64 = 64'd0;
            end else begin
                row64 = (full - 64'(nxt) + (64'd1 << (LEVEL_SHIFT - 1))) >> LEVEL_SHIFT;
                if (row64 > 64'd7) row64 = 64'd7;
            end
            r.column       = c[COL_W-1:0];
            r.slider_value = nxt;
            r.top_row      = row64[ROW_W-1:0];
            r.lit_mask     = '0;
            for (int k = 0; k < MASK_W; k++) begin
                if (full_bar_m ? (k >= int'(row64)) : (k == int'(row64)))
                    r.lit_mask[k] = 1'b1;
            end
            r.moved = (nxt != prev);
            r.last  = (c == NUM_COLS - 1);
            column_results.push_back(r);
        end
        n_ticks++;
    endtask

    task automatic apply_msg(input t_grid_msg m);
        case (m.op)
            OP_TICK:  advance_sliders();
            OP_SCENE: if (m.velocity != 0) rate_m = m.index[RATE_W-1:0];
            OP_PAD: begin
                if (m.velocity != 0)
                    target_m[m.index[2:0]] = 32'(3'd7 - m.index[5:3]) << LEVEL_SHIFT;
            end
            default: ;
        endcase
    endtask

    task automatic queue_msg(input t_op op, input logic [IDX_W-1:0] idx,
                             input logic [VEL_W-1:0] vel);
        t_grid_msg m;
        m.op       = op;
        m.index    = idx;
        m.velocity = vel;
        pending_msgs.push_back(m);
        n_queued++;
    endtask

    // Mostly ticks and real presses; releases and the unused code as noise
    task automatic queue_random(input int count);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 45)
                queue_msg(OP_TICK, 6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)));
            else if (k < 75)
                queue_msg(OP_PAD, 6'($urandom_range(0, 63)), 7'($urandom_range(1, 127)));
            else if (k < 85)
                queue_msg(OP_SCENE, 6'($urandom_range(0, 63)), 7'($urandom_range(1, 127)));
            else if (k < 93)
                queue_msg($urandom_range(0, 1) ? OP_PAD : OP_SCENE,
                          6'($urandom_range(0, 63)), 7'd0);
            else
                queue_msg(OP_UNUSED, 6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)));
        end
    endtask

    // Wait for every transaction and result, then let events settle
    task automatic drain();
        while (n_accepted != n_queued || column_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [BASE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_BASE_STEP)
            base_step_m = val;
        else
            full_bar_m = val[0];
        n_settings++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name,
                     want, got);
            n_errors++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (column_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got tdata 0x%0h",
                     $time, m_axis_tdata);
            n_errors++;
        end else begin
            want = column_results.pop_front();
            check_field("column", 32'(want.column), 32'(m_axis_tdata[2:0]));
            check_field("slider_value", want.slider_value, m_axis_tdata[34:3]);
            check_field("top_row", 32'(want.top_row), 32'(m_axis_tdata[37:35]));
            check_field("lit_mask", 32'(want.lit_mask), 32'(m_axis_tdata[45:38]));
            check_field("moved", 32'(want.moved), 32'(m_axis_tdata[46]));
            check_field("last", 32'(want.last), 32'(m_axis_tlast));
            n_checked++;
        end
    endtask

    // Input driver: holds each transaction until taken, then may idle a while
    t_grid_msg in_flight;
    int        tx_gap = 0;
    bit        tx_burst = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_msg(in_flight);
                n_accepted++;
            end
            if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_msgs.size() != 0) begin
                    in_flight = pending_msgs.pop_front();
                    s_axis_tdata  <= {1'b0, in_flight.velocity, in_flight.index,
                                      in_flight.op};
                    s_axis_tvalid <= 1'b1;
                    tx_gap = idle_len(tx_burst);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor with random receiver stalls
    int rx_gap = 0;
    bit rx_burst = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_result();
            if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
            if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                rx_gap = idle_len(rx_burst);
            end
        end
    end

    // Watchdog
    initial begin
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("grid_slew_sliders_unit test failed");
        $finish;
    end

    initial begin
        base_step_m = BASE_STEP_RESET;
        full_bar_m  = FULL_BAR_RESET;
        rate_m      = RATE_RESET;
        for (int c = 0; c < NUM_COLS; c++) begin
            level_m[c]  = '0;
            target_m[c] = '0;
        end
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, grid corners, releases, unused code, all rates
        queue_msg(OP_TICK, 6'd0, 7'd0);
        queue_msg(OP_PAD, 6'd0, 7'd127);      // column 0 to full scale
        queue_msg(OP_PAD, 6'd63, 7'd1);       // column 7 to zero
        queue_msg(OP_PAD, 6'd29, 7'd64);      // column 5 to 4/7
        queue_msg(OP_PAD, 6'd10, 7'd0);       // release, ignored
        queue_msg(OP_SCENE, 6'd0, 7'd0);      // release, ignored
        queue_msg(OP_SCENE, 6'd56, 7'd127);   // fastest rate, upper index bits set
        queue_msg(OP_TICK, 6'd63, 7'd127);
        queue_msg(OP_UNUSED, 6'd63, 7'd127);
        queue_msg(OP_TICK, 6'd21, 7'd42);
        queue_msg(OP_SCENE, 6'd7, 7'd5);      // slowest rate
        queue_msg(OP_TICK, 6'd0, 7'd0);
        for (int r = 1; r < 7; r++) begin
            queue_msg(OP_SCENE, 6'(r + 8 * r), 7'(r * 17));
            queue_msg(OP_TICK, 6'(r), 7'd0);
        end
        drain();

        // Largest step, top LED only
        write_reg(CFG_BASE_STEP, 24'hFFFFFF);
        write_reg(CFG_FULL_BAR, 24'd0);
        queue_random(100);
        drain();

        // Zero step: nothing may move
        write_reg(CFG_BASE_STEP, 24'd0);
        write_reg(CFG_FULL_BAR, 24'd1);
        queue_random(40);
        drain();

        write_reg(CFG_BASE_STEP, 24'($urandom_range(1, 24'hFFFFFF)));
        write_reg(CFG_FULL_BAR, 24'($urandom_range(0, 1)));
        queue_random(90);
        drain();

        // Small steps so slews span many ticks
        write_reg(CFG_BASE_STEP, 24'($urandom_range(1, 200000)));
        write_reg(CFG_FULL_BAR, 24'd1);
        queue_random(80);
        drain();

        if (column_results.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived", $time,
                     column_results.size());
            n_errors++;
        end
        $display("Ran %0d input transactions (%0d ticks) over %0d register writes;",
                 n_accepted, n_ticks, n_settings);
        $display("checked %0d column results, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0)
            $display("grid_slew_sliders_unit test passed");
        else
            $display("grid_slew_sliders_unit test failed");
        $finish;
    end

endmodule

// ===== grid_slew_sliders_unit.f =====
sv/gss_pkg.sv
sv/gss_front.sv
sv/gss_fifo.sv
sv/gss_back.sv
sv/grid_slew_sliders_unit.sv
bench/tb_grid_slew_sliders_unit.sv
